FILE: sv/acc_pkg.sv
package acc_pkg;

    // Default depth of the battery averaging window
    localparam int ACC_WINDOW = 30;

    // Field widths
    localparam int CH_W       = 3;
    localparam int SMP_W      = 12;
    localparam int LVL_W      = 9;
    localparam int CUR_W      = 19;
    localparam int GAIN_W     = 16;
    localparam int DB_W       = 9;
    localparam int OFF_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN     = 3'd0,
        CFG_MODE     = 3'd1,
        CFG_DEADBAND = 3'd2,
        CFG_FILL_OFF = 3'd3,
        CFG_FULL_OFF = 3'd4
    } t_cfg_idx;

    // Register values after reset
    localparam logic [GAIN_W-1:0] GAIN_RST     = 16'd1000;
    localparam logic              MODE_RST     = 1'b0;
    localparam logic [DB_W-1:0]   DEADBAND_RST = 9'd2;
    localparam logic [OFF_W-1:0]  FILL_OFF_RST = 10'd70;
    localparam logic [OFF_W-1:0]  FULL_OFF_RST = 10'd140;

    // Divider modes
    localparam logic MODE_DIV190   = 1'b0;
    localparam logic MODE_DIV33333 = 1'b1;

    // Channel numbers
    localparam logic [CH_W-1:0] CH_CURRENT = 3'd0;
    localparam logic [CH_W-1:0] CH_START   = 3'd1;
    localparam logic [CH_W-1:0] CH_BATT    = 3'd2;
    localparam logic [CH_W-1:0] CH_BOARD   = 3'd3;
    localparam logic [CH_W-1:0] CH_MOTOR   = 3'd5;

    // Level = 500*s/4095: exact reciprocal, shift 33 for a 21-bit dividend
    localparam int             LVL_K  = 33;
    localparam int             LVL_C_W = 30;
    localparam int             LVL_P_W = SMP_W + LVL_C_W;
    localparam logic [LVL_C_W-1:0] LVL_C =
        LVL_C_W'(64'd500 * (((64'd1 << LVL_K) + 64'd4094) / 64'd4095));

    // Current = s*gain/1000: reciprocal of 1000, shift 38 for a 28-bit dividend
    localparam int             CUR_K   = 38;
    localparam int             CUR_M_W = 29;
    localparam int             CUR_X_W = SMP_W + GAIN_W;
    localparam int             CUR_P_W = CUR_X_W + CUR_M_W;
    localparam logic [CUR_M_W-1:0] CUR_M =
        CUR_M_W'(((64'd1 << CUR_K) + 64'd999) / 64'd1000);

    // Battery scale, both modes brought to a common shift of 42
    localparam int             BAT_K   = 42;
    localparam int             BAT_C_W = 45;
    localparam int             BAT_P_W = LVL_W + BAT_C_W;
    localparam logic [BAT_C_W-1:0] BAT_C0 =
        BAT_C_W'((64'd1000 * (((64'd1 << 27) + 64'd189) / 64'd190)) << 15);
    localparam logic [BAT_C_W-1:0] BAT_C1 =
        BAT_C_W'(64'd100000 * (((64'd1 << BAT_K) + 64'd33332) / 64'd33333));

    // Window command and status
    typedef struct packed {
        logic             rd;
        logic             push;
        logic [SMP_W-1:0] data;
    } t_win_cmd;

    typedef struct packed {
        logic             full;
        logic [SMP_W-1:0] avg;
    } t_win_stat;

    // Item sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SCALE,
        ST_BATMUL,
        ST_WIN,
        ST_AVG,
        ST_FIN,
        ST_OUT
    } t_state;

endpackage

FILE: sv/acc_if.sv
interface acc_in_if;
    import acc_pkg::*;
    logic              valid;
    logic              ready;
    logic [CH_W-1:0]   channel;
    logic [SMP_W-1:0]  sample_value;

    modport source(output valid, channel, sample_value, input ready);
    modport sink(input valid, channel, sample_value, output ready);
endinterface

interface acc_out_if;
    import acc_pkg::*;
    logic              valid;
    logic              ready;
    logic [CUR_W-1:0]  scaled_current;
    logic [SMP_W-1:0]  peak_current_raw;
    logic [LVL_W-1:0]  start_level;
    logic [SMP_W-1:0]  battery_level;
    logic [SMP_W-1:0]  board_ntc_raw;
    logic [SMP_W-1:0]  motor_ntc_raw;

    modport source(output valid, scaled_current, peak_current_raw, start_level,
                   battery_level, board_ntc_raw, motor_ntc_raw, input ready);
    modport sink(input valid, scaled_current, peak_current_raw, start_level,
                 battery_level, board_ntc_raw, motor_ntc_raw, output ready);
endinterface

interface acc_cfg_if;
    import acc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

FILE: sv/adc_channel_conditioner.sv
// ADC channel conditioner.
// i_in takes one item per ADC sample (channel, sample_value). For each item
// accepted the block returns exactly one item on o_out holding all conditioned
// values after that sample: scaled current, peak raw current, start level,
// battery estimate and the two raw thermistor readings. i_cfg writes the
// gain, divider mode, deadband and offsets; its ready is always high.
// One item is in work at a time: i_in is ready only in the idle state, and
// an item passes the states MUL, SCALE, BATMUL and WIN, then AVG and FIN for
// a channel 2 item once the averaging window is full, then OUT. The chain of
// reciprocal multiplies (level, then battery scale, then window mean) and the
// window read-modify-write set this order.
// The window store is a ring memory with a registered read; a running
// sum is kept beside it.
// Reset clears all held values, the fill count and the running sum and loads
// the register defaults; the window store itself needs no clearing.
// A stalled receiver holds the result in the output register; the block still
// takes the next item and works it up, then waits before its own result.
module adc_channel_conditioner #(
    parameter int WINDOW = acc_pkg::ACC_WINDOW
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    acc_in_if.sink           i_in,
    acc_out_if.source        o_out,
    acc_cfg_if.sink          i_cfg
);
    import acc_pkg::*;

    // Configuration registers
    logic [GAIN_W-1:0] r_gain;
    logic              r_mode;
    logic [DB_W-1:0]   r_deadband;
    logic [OFF_W-1:0]  r_fill_off;
    logic [OFF_W-1:0]  r_full_off;

    // Sequencer
    t_state r_state, n_state;
    logic   s_in_ready, s_ld_held, s_win_step, s_ld_fin, s_ld_out;
    t_win_cmd  s_cmd;
    t_win_stat s_stat;

    // Item and arithmetic stages
    logic [CH_W-1:0]    r_ch;
    logic [SMP_W-1:0]   r_smp;
    logic [LVL_P_W-1:0] r_plvl;
    logic [CUR_X_W-1:0] r_pcur;
    logic [LVL_W-1:0]   r_lvl;
    logic [CUR_P_W-1:0] r_pcurq;
    logic [BAT_P_W-1:0] r_pbat;

    // Held values
    logic [CUR_W-1:0] r_current;
    logic [SMP_W-1:0] r_peak;
    logic [LVL_W-1:0] r_start;
    logic [SMP_W-1:0] r_battery;
    logic [SMP_W-1:0] r_board;
    logic [SMP_W-1:0] r_motor;

    // Output register
    logic             r_out_valid;
    logic [CUR_W-1:0] r_o_current;
    logic [SMP_W-1:0] r_o_peak;
    logic [LVL_W-1:0] r_o_start;
    logic [SMP_W-1:0] r_o_battery;
    logic [SMP_W-1:0] r_o_board;
    logic [SMP_W-1:0] r_o_motor;

    logic [LVL_W-1:0] s_lvl, s_diff;
    logic [SMP_W-1:0] s_bat;
    logic [SMP_W:0]   s_fill_sum, s_full_sum;

    // Config writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain     <= GAIN_RST;
            r_mode     <= MODE_RST;
            r_deadband <= DEADBAND_RST;
            r_fill_off <= FILL_OFF_RST;
            r_full_off <= FULL_OFF_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_GAIN:     r_gain     <= i_cfg.data[GAIN_W-1:0];
                CFG_MODE:     r_mode     <= i_cfg.data[0];
                CFG_DEADBAND: r_deadband <= i_cfg.data[DB_W-1:0];
                CFG_FILL_OFF: r_fill_off <= i_cfg.data[OFF_W-1:0];
                CFG_FULL_OFF: r_full_off <= i_cfg.data[OFF_W-1:0];
                default: ;
            endcase
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_in.valid) n_state = ST_MUL;
            ST_MUL:    n_state = ST_SCALE;
            ST_SCALE:  n_state = ST_BATMUL;
            ST_BATMUL: n_state = ST_WIN;
            ST_WIN: begin
                if (r_ch == CH_BATT && s_stat.full) begin
                    n_state = ST_AVG;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_AVG:    n_state = ST_FIN;
            ST_FIN:    n_state = ST_OUT;
            ST_OUT:    if (!r_out_valid || o_out.ready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_in_ready = 1'b0;
        s_ld_held  = 1'b0;
        s_win_step = 1'b0;
        s_ld_fin   = 1'b0;
        s_ld_out   = 1'b0;
        s_cmd.rd   = 1'b0;
        s_cmd.push = 1'b0;
        s_cmd.data = r_pbat[BAT_K +: SMP_W];
        case (r_state)
            ST_IDLE:   s_in_ready = 1'b1;
            ST_MUL:    s_cmd.rd   = 1'b1;
            ST_BATMUL: s_ld_held  = 1'b1;
            ST_WIN: begin
                s_win_step = (r_ch == CH_BATT);
                s_cmd.push = (r_ch == CH_BATT);
            end
            ST_FIN:    s_ld_fin   = 1'b1;
            ST_OUT:    s_ld_out   = !r_out_valid || o_out.ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign i_in.ready = s_in_ready;

    acc_window #(
        .WINDOW (WINDOW)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (s_cmd),
        .o_stat  (s_stat)
    );

    // Arithmetic stages: level and current products in MUL, current scale in SCALE, battery scale in BATMUL
    assign s_lvl = r_plvl[LVL_K +: LVL_W];

    always_ff @(posedge i_clk) begin
        if (s_in_ready && i_in.valid) begin
            r_ch  <= i_in.channel;
            r_smp <= i_in.sample_value;
        end
        if (r_state == ST_MUL) begin
            r_plvl <= LVL_P_W'(r_smp) * LVL_P_W'(LVL_C);
            r_pcur <= CUR_X_W'(r_smp) * CUR_X_W'(r_gain);
        end
        if (r_state == ST_SCALE) begin
            r_lvl   <= s_lvl;
            r_pcurq <= CUR_P_W'(r_pcur) * CUR_P_W'(CUR_M);
        end
        if (r_state == ST_BATMUL) begin
            r_pbat <= BAT_P_W'(r_lvl)
                    * BAT_P_W'((r_mode == MODE_DIV33333) ? BAT_C1 : BAT_C0);
        end
    end

    // Deadband distance and battery sums
    always_comb begin
        s_diff     = (r_lvl > r_start) ? r_lvl - r_start : r_start - r_lvl;
        s_bat      = r_pbat[BAT_K +: SMP_W];
        s_fill_sum = (SMP_W + 1)'(s_bat)
                   + ((r_mode == MODE_DIV190) ? (SMP_W + 1)'(r_fill_off) : '0);
        s_full_sum = (SMP_W + 1)'(s_stat.avg) + (SMP_W + 1)'(r_full_off);
    end

    // Held values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_current <= '0;
            r_peak    <= '0;
            r_start   <= '0;
            r_battery <= '0;
            r_board   <= '0;
            r_motor   <= '0;
        end else begin
            if (s_ld_held) begin
                case (r_ch)
                    CH_CURRENT: begin
                        r_current <= r_pcurq[CUR_K +: CUR_W];
                        if (r_smp > r_peak) r_peak <= r_smp;
                    end
                    CH_START: if (s_diff > r_deadband) r_start <= r_lvl;
                    CH_BOARD: r_board <= r_smp;
                    CH_MOTOR: r_motor <= r_smp;
                    default: ;
                endcase
            end
            // instant value while the window fills
            if (s_win_step && !s_stat.full) begin
                r_battery <= s_fill_sum[SMP_W] ? '1 : s_fill_sum[SMP_W-1:0];
            end
            // window mean once full
            if (s_ld_fin) begin
                r_battery <= s_full_sum[SMP_W] ? '1 : s_full_sum[SMP_W-1:0];
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_ld_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_ld_out) begin
            r_o_current <= r_current;
            r_o_peak    <= r_peak;
            r_o_start   <= r_start;
            r_o_battery <= r_battery;
            r_o_board   <= r_board;
            r_o_motor   <= r_motor;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.scaled_current   = r_o_current;
    assign o_out.peak_current_raw = r_o_peak;
    assign o_out.start_level      = r_o_start;
    assign o_out.battery_level    = r_o_battery;
    assign o_out.board_ntc_raw    = r_o_board;
    assign o_out.motor_ntc_raw    = r_o_motor;

endmodule

FILE: sv/acc_window.sv
module acc_window #(
    parameter int WINDOW = acc_pkg::ACC_WINDOW
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  acc_pkg::t_win_cmd   i_cmd,
    output acc_pkg::t_win_stat  o_stat
);
    import acc_pkg::*;

    localparam int PTR_W   = $clog2(WINDOW);
    localparam int FILL_W  = $clog2(WINDOW + 1);
    localparam int SUM_W   = $clog2(WINDOW * ((1 << SMP_W) - 1) + 1);
    localparam int AVG_K   = SUM_W + PTR_W;
    localparam int AVG_M_W = SUM_W + 1;
    localparam int PAVG_W  = SUM_W + AVG_M_W;
    localparam logic [AVG_M_W-1:0] AVG_M =
        AVG_M_W'(((64'd1 << AVG_K) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

    logic [SMP_W-1:0]  r_mem [WINDOW];
    logic [SMP_W-1:0]  r_old;
    logic [PTR_W-1:0]  r_ptr,  n_ptr;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [SUM_W-1:0]  r_sum,  n_sum;
    logic [PAVG_W-1:0] r_pavg;
    logic              s_full;

    assign s_full = (r_fill == FILL_W'(WINDOW));

    // Ring store: entry at the pointer is the oldest once the window is full
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_ptr] <= i_cmd.data;
        end
        if (i_cmd.rd) begin
            r_old <= r_mem[r_ptr];
        end
    end

    // Running sum: add the newest, drop the oldest when full
    always_comb begin
        n_sum  = SUM_W'({1'b0, r_sum} + (SUM_W + 1)'(i_cmd.data)
                        - (s_full ? (SUM_W + 1)'(r_old) : '0));
        n_ptr  = (r_ptr == PTR_W'(WINDOW - 1)) ? '0 : r_ptr + 1'b1;
        n_fill = s_full ? r_fill : r_fill + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr  <= '0;
            r_fill <= '0;
            r_sum  <= '0;
        end else if (i_cmd.push) begin
            r_ptr  <= n_ptr;
            r_fill <= n_fill;
            r_sum  <= n_sum;
        end
    end

    // Mean by reciprocal of the window depth
    always_ff @(posedge i_clk) begin
        r_pavg <= PAVG_W'(r_sum) * PAVG_W'(AVG_M);
    end

    assign o_stat.full = s_full;
    assign o_stat.avg  = r_pavg[AVG_K +: SMP_W];

endmodule

FILE: test/adc_channel_conditioner_test.sv
`timescale 1ns / 1ps

module adc_channel_conditioner_test;
    import acc_pkg::*;

    localparam int WINDOW      = ACC_WINDOW;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 12;
    localparam int LONG_HOLD   = 300;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 200;
    localparam logic [SMP_W-1:0] SMP_MAX = '1;

    typedef struct packed {
        logic [CH_W-1:0]  channel;
        logic [SMP_W-1:0] sample;
    } t_adc_item;

    typedef struct packed {
        logic [CUR_W-1:0] scaled_current;
        logic [SMP_W-1:0] peak_current_raw;
        logic [LVL_W-1:0] start_level;
        logic [SMP_W-1:0] battery_level;
        logic [SMP_W-1:0] board_ntc_raw;
        logic [SMP_W-1:0] motor_ntc_raw;
    } t_held_values;

    logic i_clk;
    logic i_rst_n;

    acc_in_if  in_if ();
    acc_out_if out_if ();
    acc_cfg_if cfg_if ();

    adc_channel_conditioner u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Predicted register and held state
    logic [GAIN_W-1:0] gain_reg;
    logic              mode_reg;
    logic [DB_W-1:0]   deadband_reg;
    logic [OFF_W-1:0]  fill_off_reg;
    logic [OFF_W-1:0]  full_off_reg;
    logic [LVL_W-1:0]  held_start;
    logic [SMP_W-1:0]  peak_raw;
    logic [CUR_W-1:0]  current_out;
    logic [SMP_W-1:0]  battery_out;
    logic [SMP_W-1:0]  board_ntc;
    logic [SMP_W-1:0]  motor_ntc;
    int unsigned       battery_window[$];

    // Items waiting to be sent and held values still due back
    t_adc_item    sample_queue[$];
    t_held_values held_values_due[$];
    t_adc_item    next_item;

    int unsigned issued;
    int unsigned accepted;
    int unsigned cycle_count;
    int unsigned error_count;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned hold_requests;
    int unsigned holds_served;
    int unsigned hold_left;
    logic [SMP_W-1:0] start_sample;

    // Work out the held values after one sample
    function automatic t_held_values condition_sample(logic [CH_W-1:0] ch,
                                                      logic [SMP_W-1:0] smp);
        int unsigned  level;
        int unsigned  scaled;
        int unsigned  total;
        int unsigned  diff;
        t_held_values res;
        level = (32'd500 * 32'(smp)) / 32'd4095;
        case (ch)
            CH_CURRENT: begin
                current_out = CUR_W'((32'(smp) * 32'(gain_reg)) / 32'd1000);
                if (smp > peak_raw) peak_raw = smp;
            end
            CH_START: begin
                diff = (level > held_start) ? level - held_start : held_start - level;
                if (diff > deadband_reg) held_start = LVL_W'(level);
            end
            CH_BATT: begin
                scaled = (mode_reg == MODE_DIV33333) ? (level * 32'd100000) / 32'd33333
                                                     : (level * 32'd1000) / 32'd190;
                if (battery_window.size() < WINDOW) begin
                    // window still filling: instant value, offset in divide-by-190 mode
                    battery_window.push_back(scaled);
                    if (mode_reg == MODE_DIV190) scaled += fill_off_reg;
                end else begin
                    battery_window.delete(0);
                    battery_window.push_back(scaled);
                    total = 0;
                    foreach (battery_window[k]) total += battery_window[k];
                    scaled = total / WINDOW + full_off_reg;
                end
                battery_out = (scaled > 32'(SMP_MAX)) ? SMP_MAX : SMP_W'(scaled);
            end
            CH_BOARD: board_ntc = smp;
            CH_MOTOR: motor_ntc = smp;
            default: ;
        endcase
        res.scaled_current   = current_out;
        res.peak_current_raw = peak_raw;
        res.start_level      = held_start;
        res.battery_level    = battery_out;
        res.board_ntc_raw    = board_ntc;
        res.motor_ntc_raw    = motor_ntc;
        return res;
    endfunction

    // Register write as the block sees it; spare indexes change nothing
    function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_GAIN:     gain_reg     = val[GAIN_W-1:0];
            CFG_MODE:     mode_reg     = val[0];
            CFG_DEADBAND: deadband_reg = val[DB_W-1:0];
            CFG_FILL_OFF: fill_off_reg = val[OFF_W-1:0];
            CFG_FULL_OFF: full_off_reg = val[OFF_W-1:0];
            default: ;
        endcase
    endfunction

    // Random sample, weighted towards the battery window and start deadband
    function automatic t_adc_item random_item();
        t_adc_item   it;
        int unsigned pick;
        int          nudged;
        pick = $urandom_range(99);
        if (pick < 35)      it.channel = CH_BATT;
        else if (pick < 55) it.channel = CH_START;
        else if (pick < 68) it.channel = CH_CURRENT;
        else if (pick < 76) it.channel = CH_BOARD;
        else if (pick < 84) it.channel = CH_MOTOR;
        else                it.channel = CH_W'($urandom_range(7));
        pick = $urandom_range(99);
        if (pick < 8) begin
            it.sample = '0;
        end else if (pick < 16) begin
            it.sample = SMP_MAX;
        end else if (it.channel == CH_START && pick < 80) begin
            // small step from the last start sample to probe the deadband
            nudged = int'(start_sample) + int'($urandom_range(120)) - 60;
            if (nudged < 0) nudged = 0;
            if (nudged > int'(SMP_MAX)) nudged = int'(SMP_MAX);
            it.sample = SMP_W'(nudged);
        end else begin
            it.sample = SMP_W'($urandom());
        end
        if (it.channel == CH_START) start_sample = it.sample;
        return it;
    endfunction

    task automatic queue_sample(logic [CH_W-1:0] ch, logic [SMP_W-1:0] smp);
        t_adc_item it;
        it.channel = ch;
        it.sample  = smp;
        sample_queue.push_back(it);
    endtask

    task automatic check_field(string what, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            error_count++;
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!(cfg_if.valid && cfg_if.ready));
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic set_registers(logic [CFG_DATA_W-1:0] gain, logic [CFG_DATA_W-1:0] mode,
                                 logic [CFG_DATA_W-1:0] deadband,
                                 logic [CFG_DATA_W-1:0] fill_off,
                                 logic [CFG_DATA_W-1:0] full_off);
        write_reg(CFG_GAIN, gain);
        write_reg(CFG_MODE, mode);
        write_reg(CFG_DEADBAND, deadband);
        write_reg(CFG_FILL_OFF, fill_off);
        write_reg(CFG_FULL_OFF, full_off);
    endtask

    // Wait until every item is sent and answered, then let the block settle
    task automatic drain();
        while (sample_queue.size() != 0 || issued != accepted || held_values_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Cycle limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Sample driver: holds an item until taken, idles at random between items
    always @(negedge i_clk) begin
        if (!(in_if.valid && accepted != issued)) begin
            if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_item = sample_queue.pop_front();
                in_if.valid        <= 1'b1;
                in_if.channel      <= next_item.channel;
                in_if.sample_value <= next_item.sample;
                issued             <= issued + 1;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            out_if.ready <= 1'b0;
        end else if (hold_requests != holds_served) begin
            holds_served <= holds_served + 1;
            hold_left    <= LONG_HOLD;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: check results, track register writes, predict each item taken
    always @(posedge i_clk) begin : monitor
        t_held_values want;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                if (held_values_due.size() == 0) begin
                    $display("%0t: result with nothing expected, expected none, actual %0d",
                             $time, out_if.battery_level);
                    error_count++;
                end else begin
                    want = held_values_due.pop_front();
                    check_field("scaled_current", want.scaled_current, out_if.scaled_current);
                    check_field("peak_current_raw", want.peak_current_raw,
                                out_if.peak_current_raw);
                    check_field("start_level", want.start_level, out_if.start_level);
                    check_field("battery_level", want.battery_level, out_if.battery_level);
                    check_field("board_ntc_raw", want.board_ntc_raw, out_if.board_ntc_raw);
                    check_field("motor_ntc_raw", want.motor_ntc_raw, out_if.motor_ntc_raw);
                end
            end
            if (cfg_if.valid && cfg_if.ready) apply_register(cfg_if.index, cfg_if.data);
            if (in_if.valid && in_if.ready) begin
                held_values_due.push_back(condition_sample(in_if.channel, in_if.sample_value));
                accepted <= accepted + 1;
            end
        end
    end

    // Stimulus sequence
    initial begin
        int unsigned counted;
        t_adc_item   it;

        in_if.valid        = 1'b0;
        in_if.channel      = '0;
        in_if.sample_value = '0;
        out_if.ready       = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = '0;
        cfg_if.data        = '0;
        issued        = 0;
        accepted      = 0;
        cycle_count   = 0;
        error_count   = 0;
        hold_requests = 0;
        holds_served  = 0;
        hold_left     = 0;
        start_sample  = '0;
        send_idle_pct = 31;
        recv_idle_pct = 60;

        // state after reset
        gain_reg     = GAIN_RST;
        mode_reg     = MODE_RST;
        deadband_reg = DEADBAND_RST;
        fill_off_reg = FILL_OFF_RST;
        full_off_reg = FULL_OFF_RST;
        held_start   = '0;
        peak_raw     = '0;
        current_out  = '0;
        battery_out  = '0;
        board_ntc    = '0;
        motor_ntc    = '0;
        battery_window.delete();

        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: current extremes and peak hold
        queue_sample(CH_CURRENT, '0);
        queue_sample(CH_CURRENT, SMP_MAX);
        queue_sample(CH_CURRENT, 12'd1234);
        // start level: full scale, step inside the deadband, step just beyond
        queue_sample(CH_START, SMP_MAX);
        queue_sample(CH_START, 12'd4079);
        queue_sample(CH_START, 12'd4071);
        queue_sample(CH_START, '0);
        // window fill with the fill offset
        queue_sample(CH_BATT, '0);
        queue_sample(CH_BATT, SMP_MAX);
        queue_sample(CH_BATT, 12'd2048);
        queue_sample(CH_BOARD, 12'd2730);
        queue_sample(CH_MOTOR, 12'd1365);
        // every channel at full scale, unused ones included
        for (int c = 0; c < 2 ** CH_W; c++) queue_sample(CH_W'(c), SMP_MAX);
        drain();

        // window fill in the other divider mode: no offset
        write_reg(CFG_MODE, 16'(MODE_DIV33333));
        queue_sample(CH_BATT, SMP_MAX);
        queue_sample(CH_BATT, 12'd1000);
        queue_sample(CH_BOARD, '0);
        queue_sample(CH_MOTOR, '0);
        drain();

        // Random phases, each with its own register setting
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: set_registers(16'hFFFF, 16'(MODE_DIV190), 16'h0000, 16'hFFFF, 16'hFFFF);
                1: begin
                    set_registers(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
                    // writes past the last register must change nothing
                    for (int i = CFG_FULL_OFF + 1; i < 2 ** CFG_IDX_W; i++)
                        write_reg(CFG_IDX_W'(i), 16'hFFFF);
                end
                default: set_registers(16'($urandom()), 16'($urandom()),
                                       {7'($urandom_range(127)), 9'($urandom_range(12))},
                                       16'($urandom()), 16'($urandom()));
            endcase
            if (ph < 2) begin
                send_idle_pct = 31;
                recv_idle_pct = 60;
            end else if (ph < 4) begin
                send_idle_pct = 60;
                recv_idle_pct = 31;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // long receiver hold-off while the sender keeps offering items
            if (ph == PHASES - 1) hold_requests++;
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                it = random_item();
                sample_queue.push_back(it);
                if (it.channel inside {CH_CURRENT, CH_START, CH_BATT, CH_BOARD, CH_MOTOR})
                    counted++;
            end
            drain();
        end

        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
